FILE: rtl/core/sacl_pkg.sv
// sacl_pkg: shared codes, state encoding and control structs for the cache
// used by sacl_ctrl, sacl_dp and set_assoc_cache_lru_coherent; no dependencies
package sacl_pkg;

  // command codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_FETCH = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_INVAL = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  // message codes
  localparam logic [1:0] MSG_NONE      = 2'd0;
  localparam logic [1:0] MSG_WR_CLEAN  = 2'd1;
  localparam logic [1:0] MSG_WR_MISS   = 2'd2;
  localparam logic [1:0] MSG_RD_MISS   = 2'd3;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_TAG   = 4'b0100,
    S_DATA  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

FILE: rtl/core/sacl_ctrl.sv
// sacl_ctrl: sequencing state machine of the cache (clear, lookup, data)
// depends on sacl_pkg
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_TAG;
        end
      end
      S_TAG: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_DATA;
      end
      S_DATA: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/core/sacl_dp.sv
// sacl_dp: tag, lru and line byte memories, lookup, replacement and result
// registers; depends on sacl_pkg, driven by sacl_ctrl commands
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic        cfg_level,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_allocate_for_write,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_message,
  output logic        out_evicted,
  output logic        out_evicted_dirty,
  output logic [31:0] out_evicted_address,
  output logic        out_was_dirty
);

  localparam int AB    = ADDR_BITS;
  localparam int OB    = $clog2(LINE_BYTES);
  localparam int IB    = $clog2(SETS);
  localparam int OBW   = (OB > 0) ? OB : 1;
  localparam int IBW   = (IB > 0) ? IB : 1;
  localparam int TB    = AB - OB - IB;
  localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW    = TB + 1;
  localparam int DEPTH = SETS * WAYS * LINE_BYTES;
  localparam int BAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NL    = SETS * WAYS;
  localparam int NLW   = (NL > 1) ? $clog2(NL) : 1;

  // memories
  logic [WAYS*EW-1:0] tag_mem  [SETS];
  logic [WAYS*WB-1:0] lru_mem  [SETS];
  logic [7:0]         byte_mem [DEPTH];

  logic [NL-1:0]   valid_r;
  logic [SETS-1:0] lru_ok_r;
  logic            level_r;
  logic [BAW-1:0]  clr_cnt_r;

  // captured item
  logic [2:0]         cmd_r;
  logic [TB-1:0]      tag_r;
  logic [IBW-1:0]     set_r;
  logic [OBW-1:0]     off_r;
  logic [7:0]         wdata_r;
  logic               afw_r;
  logic [WAYS*EW-1:0] tag_rd_r;
  logic [WAYS*WB-1:0] lru_rd_r;

  // lookup results
  logic        hit_r, use_wd_r, rd_en_r, ev_r, evd_r, wd_r;
  logic [1:0]  msg_r;
  logic [31:0] eva_r;
  logic [7:0]  byte_rd_r;

  // address split
  logic [AB-1:0]  a, off_full, set_full;
  logic [OBW-1:0] off_c;
  logic [IBW-1:0] set_c;
  logic [TB-1:0]  tag_c;

  always_comb begin
    a        = AB'(in_address);
    off_full = a & AB'((1 << OB) - 1);
    set_full = (a >> OB) & AB'((1 << IB) - 1);
    if (off_full >= AB'(LINE_BYTES)) off_full = off_full - AB'(LINE_BYTES);
    if (set_full >= AB'(SETS)) set_full = set_full - AB'(SETS);
    off_c = OBW'(off_full);
    set_c = IBW'(set_full);
    tag_c = TB'(a >> (OB + IB));
  end

  // lookup logic
  logic [WAYS-1:0]    match, vbits;
  logic               any_hit, any_empty;
  logic [WB-1:0]      hit_way, free_way, alloc_way, acc_way;
  logic [WAYS*WB-1:0] lru_row, lru_new;
  logic [WAYS-1:0]    past;
  logic [TB-1:0]      vic_tag;
  logic               acc_dirty;
  logic [AB-1:0]      ev_full;
  logic [BAW-1:0]     baddr;
  logic [WAYS*EW-1:0] tag_wr;
  logic               is_lookup;

  always_comb begin
    any_hit   = 1'b0;
    any_empty = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      vbits[w] = valid_r[NLW'(set_r) * NLW'(WAYS) + NLW'(w)];
      match[w] = vbits[w] && (tag_rd_r[w*EW +: TB] == tag_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = WB'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!vbits[w]) begin
        any_empty = 1'b1;
        free_way  = WB'(w);
      end
    end
    // replacement order, reset order until first written
    for (int w = 0; w < WAYS; w++) begin
      lru_row[w*WB +: WB] = lru_ok_r[set_r] ? lru_rd_r[w*WB +: WB] : WB'(w);
    end
    alloc_way = any_empty ? free_way : lru_row[0 +: WB];
    // move allocated way to most recent
    for (int q = 0; q < WAYS; q++) begin
      past[q] = (lru_row[q*WB +: WB] == alloc_way) || ((q > 0) ? past[(q>0)?q-1:0] : 1'b0);
    end
    for (int q = 0; q < WAYS; q++) begin
      if (q == WAYS - 1) lru_new[q*WB +: WB] = alloc_way;
      else if (past[q])  lru_new[q*WB +: WB] = lru_row[((q+1<WAYS)?q+1:q)*WB +: WB];
      else               lru_new[q*WB +: WB] = lru_row[q*WB +: WB];
    end
    is_lookup = (cmd_r == CMD_READ) || (cmd_r == CMD_FETCH) || (cmd_r == CMD_WRITE);
    acc_way   = (cmd_r == CMD_ALLOC) ? alloc_way : hit_way;
    vic_tag   = tag_rd_r[int'(acc_way)*EW +: TB];
    acc_dirty = tag_rd_r[int'(acc_way)*EW + TB];
    ev_full   = (AB'(vic_tag) << (OB + IB)) | (AB'(set_r) << OB);
    baddr     = (BAW'(set_r) * BAW'(WAYS) + BAW'(hit_way)) * BAW'(LINE_BYTES) + BAW'(off_r);
    tag_wr    = tag_rd_r;
    if (cmd_r == CMD_ALLOC) begin
      tag_wr[int'(alloc_way)*EW +: EW] = {afw_r, tag_r};
    end else begin
      tag_wr[int'(hit_way)*EW + TB] = 1'b1;
    end
  end

  // tag and lru memories
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tag_rd_r <= tag_mem[set_c];
      lru_rd_r <= lru_mem[set_c];
    end
    if (cmd.lookup && cmd_r == CMD_ALLOC) begin
      tag_mem[set_r] <= tag_wr;
      lru_mem[set_r] <= lru_new;
    end else if (cmd.lookup && cmd_r == CMD_WRITE && any_hit) begin
      tag_mem[set_r] <= tag_wr;
    end
  end

  // line byte memory with clearing pass after reset
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      byte_mem[clr_cnt_r] <= 8'd0;
    end else if (cmd.lookup && cmd_r == CMD_WRITE && any_hit) begin
      byte_mem[baddr] <= wdata_r;
    end
    if (cmd.lookup) byte_rd_r <= byte_mem[baddr];
  end

  assign stat.clear_done = (clr_cnt_r == BAW'(DEPTH - 1));

  // control state: valid bits, lru valid, level, clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      lru_ok_r  <= '0;
      level_r   <= 1'b0;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cfg_we) level_r <= cfg_level;
      if (cmd.clear_step && !stat.clear_done) clr_cnt_r <= clr_cnt_r + BAW'(1);
      if (cmd.lookup && cmd_r == CMD_ALLOC) begin
        valid_r[NLW'(set_r) * NLW'(WAYS) + NLW'(alloc_way)] <= 1'b1;
        lru_ok_r[set_r] <= 1'b1;
      end else if (cmd.lookup && cmd_r == CMD_INVAL && any_hit) begin
        valid_r[NLW'(set_r) * NLW'(WAYS) + NLW'(hit_way)] <= 1'b0;
      end
    end
  end

  // item capture and lookup results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      tag_r   <= tag_c;
      set_r   <= set_c;
      off_r   <= off_c;
      wdata_r <= in_write_data;
      afw_r   <= in_allocate_for_write;
    end
    if (cmd.lookup) begin
      hit_r    <= 1'b0;
      msg_r    <= MSG_NONE;
      ev_r     <= 1'b0;
      evd_r    <= 1'b0;
      eva_r    <= '0;
      wd_r     <= 1'b0;
      rd_en_r  <= 1'b0;
      use_wd_r <= (cmd_r == CMD_WRITE);
      if (is_lookup) begin
        hit_r   <= any_hit;
        rd_en_r <= any_hit;
        if (!any_hit)                  msg_r <= (cmd_r == CMD_WRITE) ? MSG_WR_MISS : MSG_RD_MISS;
        else if (cmd_r == CMD_WRITE && !acc_dirty) msg_r <= MSG_WR_CLEAN;
      end else if (cmd_r == CMD_ALLOC) begin
        if (!any_empty) begin
          if (level_r) begin
            ev_r  <= 1'b1;
            evd_r <= acc_dirty;
            eva_r <= 32'(ev_full);
          end else if (acc_dirty) begin
            ev_r  <= 1'b1;
            evd_r <= 1'b1;
          end
        end
      end else if (cmd_r == CMD_INVAL || cmd_r == CMD_QUERY) begin
        hit_r <= any_hit;
        wd_r  <= any_hit && acc_dirty;
      end
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit             <= hit_r;
      out_read_data       <= !rd_en_r ? 8'd0 : (use_wd_r ? wdata_r : byte_rd_r);
      out_message         <= msg_r;
      out_evicted         <= ev_r;
      out_evicted_dirty   <= evd_r;
      out_evicted_address <= eva_r;
      out_was_dirty       <= wd_r;
    end
  end

endmodule

FILE: rtl/core/set_assoc_cache_lru_coherent.sv
// set_assoc_cache_lru_coherent: write-back set-associative cache array, lru order per set, updated on allocation
// each item passes through the tag/lru memory read, then the line byte memory read
// and lookup, then the output register; busy stays high until the item reaches the
// output register, and no new item is taken while busy
// after reset a clearing pass zeroes all SETS*WAYS*LINE_BYTES line bytes (8192 by
// default), one byte a cycle, with busy high
// the receiver cannot stall; config writes are always ready
module set_assoc_cache_lru_coherent
  import sacl_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_allocate_for_write,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_message,
  output logic        out_evicted,
  output logic        out_evicted_dirty,
  output logic [31:0] out_evicted_address,
  output logic        out_was_dirty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_cache_level
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  // controller
  sacl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  sacl_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_level             (cfg_cache_level),
    .in_command            (in_command),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .in_allocate_for_write (in_allocate_for_write),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_read_data         (out_read_data),
    .out_message           (out_message),
    .out_evicted           (out_evicted),
    .out_evicted_dirty     (out_evicted_dirty),
    .out_evicted_address   (out_evicted_address),
    .out_was_dirty         (out_was_dirty)
  );

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after transfer");

  // results strobe for a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // a dirty eviction is always an eviction
  a_evict_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_dirty) |-> out_evicted) else $error("dirty without evict");

  // a hit never reports a miss message
  a_hit_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_message != MSG_WR_MISS && out_message != MSG_RD_MISS))
    else $error("miss message on hit");

endmodule
